// ----- rtl/iart_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iart_pkg
// Request and status codes used by the address range table and its testbench.
// ----------------------------------------------------------------------------
package iart_pkg;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int DEV_W    = 16;
  localparam int COUNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SKIPPED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'h7f;

endpackage

// ----- rtl/iart_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iart_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module iart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/io_address_range_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_address_range_table
// Table of inclusive address ranges tagged with device ids: insert, lookup,
// remove-by-device.
// ----------------------------------------------------------------------------
// Usage:
//   A request is accepted on a rising edge with start high and busy low. The
//   fields req_type, range_low, range_high, owner_id and the four flag bits
//   are sampled at that edge. Exactly one result follows: done is high for one
//   cycle with status, found_device and removed_count valid in that cycle.
//   The receiver cannot stall; the result is gone after that cycle.
//   An insert that fails the filter and the unused request code skip the scan
//   and answer directly. Every other request scans all slots of the table RAM
//   from slot 0 upward, one read a cycle through its single read port, before
//   it answers. busy is low in the done cycle, so a new request may be accepted
//   there; no new request is taken while one is in progress.
//   Removals write back cleared entries during the scan; an insert writes its
//   entry into the lowest free slot at the clock edge that raises done.
//   Reset: after rst the block runs a clearing pass over every RAM slot
//   with busy high, then goes idle with an empty table.
// ----------------------------------------------------------------------------
module io_address_range_table
  import iart_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDR_BITS     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [63:0]         range_low,
  input  logic [63:0]         range_high,
  input  logic [DEV_W-1:0]    owner_id,
  input  logic                res_is_io,
  input  logic                res_is_mem,
  input  logic                check_supported,
  input  logic                check_disabled,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [DEV_W-1:0]    found_device,
  output logic [COUNT_W-1:0]  removed_count
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_W = 1 + 2 * ADDR_BITS + DEV_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // latched request
  logic [REQ_W-1:0]     req;
  logic [ADDR_BITS-1:0] req_low;
  logic [ADDR_BITS-1:0] req_high;
  logic [DEV_W-1:0]     req_dev;
  logic                 skip;

  // scan bookkeeping
  logic [IDX_W-1:0] scan_addr;
  logic             issue_on;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic             match_found;
  logic             match_same;
  logic [DEV_W-1:0] match_dev;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [COUNT_W-1:0] rm_count;

  // ram ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic                 e_valid;
  logic [ADDR_BITS-1:0] e_low;
  logic [ADDR_BITS-1:0] e_high;
  logic [DEV_W-1:0]     e_dev;

  logic [ADDR_BITS-1:0] in_low;
  logic [ADDR_BITS-1:0] in_high;
  logic                 in_filtered;

  logic lookup_hit;
  logic insert_inside;
  logic remove_hit;
  logic do_insert;

  iart_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_addr),
    .rdata(ram_rdata)
  );

  assign {e_valid, e_low, e_high, e_dev} = ram_rdata;

  assign in_low  = range_low[ADDR_BITS-1:0];
  assign in_high = range_high[ADDR_BITS-1:0];

  // insert filter: capability flags, resource kind and degenerate bounds
  assign in_filtered = !check_supported || check_disabled || !(res_is_io || res_is_mem)
                       || (in_low == '0) || (in_low == '1)
                       || (in_high == '0) || (in_high == '1);

  assign lookup_hit    = e_valid && (e_low <= req_low) && (req_low <= e_high);
  assign insert_inside = e_valid && (e_low <= req_low) && (req_high <= e_high);
  assign remove_hit    = e_valid && (e_dev == req_dev);

  assign do_insert = (state == S_DONE) && !skip && (req == REQ_INSERT)
                     && !match_found && free_found;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = scan_addr;
    end else if (do_insert) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = {1'b1, req_low, req_high, req_dev};
    end else if ((state == S_SCAN) && chk_valid && (req == REQ_REMOVE) && remove_hit) begin
      ram_we    = 1'b1;
      ram_waddr = chk_idx;
      ram_wdata = {1'b0, e_low, e_high, e_dev};
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan_addr <= '0;
      issue_on  <= 1'b0;
      chk_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (scan_addr == LAST_IDX) begin
            scan_addr <= '0;
            state     <= S_IDLE;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            req         <= req_type;
            req_low     <= in_low;
            req_high    <= in_high;
            req_dev     <= owner_id;
            match_found <= 1'b0;
            match_same  <= 1'b0;
            match_dev   <= '0;
            free_found  <= 1'b0;
            free_idx    <= '0;
            rm_count    <= '0;
            scan_addr   <= '0;
            chk_valid   <= 1'b0;
            if ((req_type == REQ_UNUSED) || ((req_type == REQ_INSERT) && in_filtered)) begin
              skip  <= 1'b1;
              state <= S_DONE;
            end else begin
              skip     <= 1'b0;
              issue_on <= 1'b1;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // read for slot scan_addr is issued now, checked next cycle
          chk_valid <= issue_on;
          chk_idx   <= scan_addr;
          if (issue_on) begin
            if (scan_addr == LAST_IDX) begin
              issue_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
          if (chk_valid) begin
            case (req)
              REQ_LOOKUP: begin
                if (lookup_hit && !match_found) begin
                  match_found <= 1'b1;
                  match_dev   <= e_dev;
                end
              end
              REQ_INSERT: begin
                if (insert_inside) begin
                  if (!match_found) begin
                    match_found <= 1'b1;
                    match_same  <= (e_dev == req_dev) && (e_low == req_low)
                                   && (e_high == req_high);
                  end
                end else if (!e_valid && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= chk_idx;
                end
              end
              REQ_REMOVE: begin
                if (remove_hit && (rm_count != COUNT_MAX)) begin
                  rm_count <= rm_count + 1'b1;
                end
              end
              default: begin
              end
            endcase
            if (chk_idx == LAST_IDX) begin
              chk_valid <= 1'b0;
              state     <= S_DONE;
            end
          end
        end
        S_DONE: begin
          done          <= 1'b1;
          found_device  <= '0;
          removed_count <= '0;
          if (skip) begin
            status <= ST_SKIPPED;
          end else begin
            case (req)
              REQ_INSERT: begin
                if (match_found) begin
                  status <= match_same ? ST_PRESENT : ST_OVERLAP;
                end else if (free_found) begin
                  status <= ST_INSERTED;
                end else begin
                  status <= ST_FULL;
                end
              end
              REQ_LOOKUP: begin
                if (match_found) begin
                  status       <= ST_HIT;
                  found_device <= match_dev;
                end else begin
                  status <= ST_MISS;
                end
              end
              REQ_REMOVE: begin
                status        <= ST_MISS;
                removed_count <= rm_count;
              end
              default: begin
                status <= ST_SKIPPED;
              end
            endcase
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/tb_io_address_range_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_io_address_range_table
// Self-checking bench for the address range table. A queue of requests feeds
// a clocked driver. Every accepted transaction goes through a table model kept
// here, which yields the expected status, device and removal count. A clocked
// monitor checks each done strobe against the oldest expected answer.
// ----------------------------------------------------------------------------
module tb_io_address_range_table;
  import iart_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_BITS     = 64;
  localparam int CLK_PERIOD    = 20;
  localparam int RANDOM_ITEMS  = 1600;
  localparam logic [63:0] ADDR_MASK =
    (ADDR_BITS == 64) ? 64'hffff_ffff_ffff_ffff : ((64'd1 << ADDR_BITS) - 64'd1);

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [DEV_W-1:0] dev;
    logic             io;
    logic             mem;
    logic             sup;
    logic             dis;
    bit               drain_first;
  } range_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DEV_W-1:0]    dev;
    logic [COUNT_W-1:0]  count;
  } range_answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [REQ_W-1:0]    req_type = '0;
  logic [63:0]         range_low = '0;
  logic [63:0]         range_high = '0;
  logic [DEV_W-1:0]    owner_id = '0;
  logic                res_is_io = 1'b0;
  logic                res_is_mem = 1'b0;
  logic                check_supported = 1'b0;
  logic                check_disabled = 1'b0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [DEV_W-1:0]    found_device;
  logic [COUNT_W-1:0]  removed_count;

  range_req_t    pending_q[$];
  range_req_t    inserted_ranges[$];
  range_answer_t answer_q[$];
  range_req_t    in_flight;
  int            n_queued = 0;
  int            n_accepted = 0;
  int            n_errors = 0;

  // table model
  bit               tbl_valid [TABLE_ENTRIES];
  logic [63:0]      tbl_lo [TABLE_ENTRIES];
  logic [63:0]      tbl_hi [TABLE_ENTRIES];
  logic [DEV_W-1:0] tbl_dev [TABLE_ENTRIES];

  logic [DEV_W-1:0] dev_pool [8];

  io_address_range_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .range_low(range_low),
    .range_high(range_high),
    .owner_id(owner_id),
    .res_is_io(res_is_io),
    .res_is_mem(res_is_mem),
    .check_supported(check_supported),
    .check_disabled(check_disabled),
    .done(done),
    .status(status),
    .found_device(found_device),
    .removed_count(removed_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic range_answer_t table_answer(range_req_t r);
    range_answer_t a;
    logic [63:0]   lo;
    logic [63:0]   hi;
    int            free_idx;
    bit            settled;
    a.status = ST_SKIPPED;
    a.dev    = '0;
    a.count  = '0;
    lo = r.lo & ADDR_MASK;
    hi = r.hi & ADDR_MASK;
    settled = 1'b0;
    free_idx = -1;
    case (r.req_type)
      REQ_INSERT: begin
        if (r.sup && !r.dis && (r.io || r.mem) && lo != '0 && lo != ADDR_MASK &&
            hi != '0 && hi != ADDR_MASK) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (settled) begin
              // first containing slot already decided the answer
            end else if (tbl_valid[i]) begin
              if (tbl_lo[i] <= lo && hi <= tbl_hi[i]) begin
                settled = 1'b1;
                if (tbl_dev[i] == r.dev && tbl_lo[i] == lo && tbl_hi[i] == hi)
                  a.status = ST_PRESENT;
                else
                  a.status = ST_OVERLAP;
              end
            end else if (free_idx < 0) begin
              free_idx = i;
            end
          end
          if (!settled) begin
            if (free_idx < 0) begin
              a.status = ST_FULL;
            end else begin
              tbl_valid[free_idx] = 1'b1;
              tbl_lo[free_idx]    = lo;
              tbl_hi[free_idx]    = hi;
              tbl_dev[free_idx]   = r.dev;
              a.status = ST_INSERTED;
            end
          end
        end
      end
      REQ_LOOKUP: begin
        a.status = ST_MISS;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!settled && tbl_valid[i] && tbl_lo[i] <= lo && lo <= tbl_hi[i]) begin
            settled  = 1'b1;
            a.status = ST_HIT;
            a.dev    = tbl_dev[i];
          end
        end
      end
      REQ_REMOVE: begin
        a.status = ST_MISS;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_dev[i] == r.dev) begin
            tbl_valid[i] = 1'b0;
            if (a.count != COUNT_MAX) a.count = a.count + 1'b1;
          end
        end
      end
      default: begin
        a.status = ST_SKIPPED;
      end
    endcase
    return a;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic queue_req(input range_req_t r);
    pending_q.push_back(r);
    n_queued++;
    if (r.req_type == REQ_INSERT) begin
      inserted_ranges.push_back(r);
      if (inserted_ranges.size() > 64) void'(inserted_ranges.pop_front());
    end
  endtask

  task automatic add_req(input logic [REQ_W-1:0] kind, input logic [63:0] lo,
                         input logic [63:0] hi, input logic [DEV_W-1:0] dev,
                         input int io, input int mem, input int sup,
                         input int dis, input int drain);
    range_req_t r;
    r.req_type    = kind;
    r.lo          = lo;
    r.hi          = hi;
    r.dev         = dev;
    r.io          = (io != 0);
    r.mem         = (mem != 0);
    r.sup         = (sup != 0);
    r.dis         = (dis != 0);
    r.drain_first = (drain != 0);
    queue_req(r);
  endtask

  function automatic range_req_t make_random_req(bit fill_phase);
    range_req_t  r;
    range_req_t  prev;
    logic [63:0] tmp;
    int          pick;
    int          sel;
    r.drain_first = 1'b0;
    r.dev = dev_pool[$urandom_range(0, 7)];
    if ($urandom_range(0, 9) == 0) r.dev = DEV_W'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      r.sup = 1'b1;
      r.dis = 1'b0;
      {r.io, r.mem} = 2'($urandom_range(1, 3));
    end else begin
      {r.io, r.mem, r.sup, r.dis} = 4'($urandom_range(0, 15));
    end
    pick = $urandom_range(0, 99);
    if (pick < (fill_phase ? 70 : 40))      r.req_type = REQ_INSERT;
    else if (pick < (fill_phase ? 90 : 80)) r.req_type = REQ_LOOKUP;
    else if (pick < 97)                     r.req_type = REQ_REMOVE;
    else                                    r.req_type = REQ_UNUSED;

    case ($urandom_range(0, 3))
      0: r.lo = 64'h0000_0000_0001_0000;
      1: r.lo = 64'h0000_00f0_0000_0000;
      2: r.lo = 64'h8000_0000_0000_0000;
      default: r.lo = 64'hffff_ffff_ffff_0000;
    endcase
    r.lo = r.lo + 64'($urandom_range(0, 4095));
    r.hi = r.lo + 64'($urandom_range(0, 4095));
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      r.lo = {$urandom, $urandom};
      r.hi = {$urandom, $urandom};
    end else if (sel < 10) begin
      tmp  = r.lo;
      r.lo = r.hi + 64'd1;
      r.hi = tmp;
    end else if (sel < 13) begin
      if ($urandom_range(0, 1)) r.lo = $urandom_range(0, 1) ? '0 : '1;
      else                      r.hi = $urandom_range(0, 1) ? '0 : '1;
    end

    if (inserted_ranges.size() != 0) begin
      prev = inserted_ranges[$urandom_range(0, inserted_ranges.size() - 1)];
      if (r.req_type == REQ_INSERT && $urandom_range(0, 99) < 30) begin
        // reuse a past range: exact repeat, same bounds new owner, or a subrange
        sel = $urandom_range(0, 2);
        r.lo = prev.lo;
        r.hi = prev.hi;
        if (sel == 0) begin
          r.dev = prev.dev;
        end else if (sel == 2) begin
          r.lo = prev.lo + 64'($urandom_range(0, 3));
          r.hi = prev.hi - 64'($urandom_range(0, 3));
        end
      end else if (r.req_type == REQ_LOOKUP && $urandom_range(0, 99) < 60) begin
        case ($urandom_range(0, 4))
          0: r.lo = prev.lo;
          1: r.lo = prev.hi;
          2: r.lo = prev.lo - 64'd1;
          3: r.lo = prev.hi + 64'd1;
          default: r.lo = prev.lo + ((prev.hi - prev.lo) >> 1);
        endcase
      end else if (r.req_type == REQ_REMOVE && $urandom_range(0, 99) < 50) begin
        r.dev = prev.dev;
      end
    end
    return r;
  endfunction

  // driver: holds a transaction until busy drops, then moves to the next one
  always @(posedge clk) begin : driver
    range_req_t nxt;
    bit         may_send;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        answer_q.push_back(table_answer(in_flight));
        n_accepted++;
      end
      if (!(start && busy)) begin
        may_send = (pending_q.size() != 0);
        if (may_send && pending_q[0].drain_first && answer_q.size() != 0)
          may_send = 1'b0;
        // no idling in the middle stretch
        if (may_send && !(n_accepted >= 700 && n_accepted < 1000) &&
            $urandom_range(0, 99) < 11)
          may_send = 1'b0;
        if (may_send) begin
          nxt = pending_q.pop_front();
          in_flight       <= nxt;
          req_type        <= nxt.req_type;
          range_low       <= nxt.lo;
          range_high      <= nxt.hi;
          owner_id        <= nxt.dev;
          res_is_io       <= nxt.io;
          res_is_mem      <= nxt.mem;
          check_supported <= nxt.sup;
          check_disabled  <= nxt.dis;
          start           <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    range_answer_t want;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        report($sformatf("result with nothing outstanding, status %0d", status));
      end else begin
        want = answer_q.pop_front();
        if (status !== want.status)
          report($sformatf("status got %0d want %0d", status, want.status));
        if (found_device !== want.dev)
          report($sformatf("found_device got %h want %h", found_device, want.dev));
        if (removed_count !== want.count)
          report($sformatf("removed_count got %0d want %0d", removed_count, want.count));
      end
    end
  end

  initial begin
    #(64'd1_000_000 * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    range_req_t  r;
    logic [63:0] ones;
    ones = '1;
    for (int i = 0; i < 8; i++) dev_pool[i] = DEV_W'($urandom);

    // directed: empty table, filter cases, containment, inverted and extreme ranges
    add_req(REQ_LOOKUP, 64'h1000, '0, '0, 0, 0, 0, 0, 0);
    add_req(REQ_REMOVE, '0, '0, 16'h00a1, 0, 0, 0, 0, 0);
    add_req(REQ_UNUSED, ones, ones, 16'hffff, 1, 1, 1, 1, 0);
    add_req(REQ_INSERT, 64'h1000, 64'h1fff, 16'h00a1, 1, 0, 0, 0, 0);
    add_req(REQ_INSERT, 64'h1000, 64'h1fff, 16'h00a1, 1, 0, 1, 1, 0);
    add_req(REQ_INSERT, 64'h1000, 64'h1fff, 16'h00a1, 0, 0, 1, 0, 0);
    add_req(REQ_INSERT, '0, 64'h1fff, 16'h00a1, 1, 0, 1, 0, 0);
    add_req(REQ_INSERT, 64'h1000, ones, 16'h00a1, 1, 0, 1, 0, 0);
    add_req(REQ_INSERT, ones, 64'h2000, 16'h00a1, 0, 1, 1, 0, 0);
    add_req(REQ_INSERT, 64'h1000, '0, 16'h00a1, 0, 1, 1, 0, 0);
    add_req(REQ_INSERT, 64'h1000, 64'h1fff, 16'h00a1, 1, 0, 1, 0, 0);
    add_req(REQ_INSERT, 64'h1000, 64'h1fff, 16'h00a1, 1, 0, 1, 0, 0);
    add_req(REQ_INSERT, 64'h1100, 64'h1200, 16'h0b02, 0, 1, 1, 0, 0);
    add_req(REQ_INSERT, 64'h1000, 64'h1fff, 16'h0b02, 1, 0, 1, 0, 0);
    add_req(REQ_INSERT, 64'h1800, 64'h2800, 16'h0b02, 1, 1, 1, 0, 0);
    add_req(REQ_INSERT, 64'h5000, 64'h4000, 16'h00a1, 1, 0, 1, 0, 0);
    add_req(REQ_INSERT, 64'h1, ones - 64'd1, 16'hffff, 0, 1, 1, 0, 0);
    add_req(REQ_LOOKUP, 64'h4800, '0, '0, 0, 0, 0, 0, 0);
    add_req(REQ_LOOKUP, 64'h1900, '0, '0, 0, 0, 0, 0, 0);
    add_req(REQ_LOOKUP, 64'h2800, '0, '0, 0, 0, 0, 0, 0);
    add_req(REQ_LOOKUP, ones, '0, '0, 0, 0, 0, 0, 0);
    add_req(REQ_LOOKUP, '0, '0, '0, 0, 0, 0, 0, 0);
    // table must be quiet before this removal goes in
    add_req(REQ_REMOVE, '0, '0, 16'h00a1, 0, 0, 0, 0, 1);
    add_req(REQ_LOOKUP, 64'h1900, '0, '0, 0, 0, 0, 0, 0);
    add_req(REQ_REMOVE, '0, '0, 16'hffff, 0, 0, 0, 0, 0);

    // random: alternating insert-heavy stretches that fill the table, then mixed
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = make_random_req(((i / 200) % 2) == 0);
      if (i % 400 == 399) r.drain_first = 1'b1;
      queue_req(r);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_queued) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
